>>> rtl/core/spd_pkg.sv
// Shared types, constants and coefficient table for the seven-point stencil core.
package spd_pkg;

  // Scale registers: signed Q(frac) values, fixed width
  localparam int SCALE_BITS = 48;
  localparam int SCALE_LO_BITS = SCALE_BITS / 2;
  localparam logic [SCALE_BITS-1:0] SCALE_RESET = 48'd16777216;

  // Coefficients fit in 14 signed bits; a row's absolute sum stays below 2^15
  localparam int COEF_BITS = 14;
  localparam int SUM_GROWTH = 15;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE_FIRST = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE_SECOND = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE_THIRD = 2'd2;

  // Derivative order codes
  localparam logic [1:0] ORD_NONE = 2'd0;
  localparam logic [1:0] ORD_FIRST = 2'd1;
  localparam logic [1:0] ORD_SECOND = 2'd2;
  localparam logic [1:0] ORD_THIRD = 2'd3;

  // Per-item tag carried along the pipeline
  typedef struct packed {
    logic       bad_order;
    logic [1:0] deriv_order;
  } spd_tag_t;

  // Stencil rows: [position][order-1][tap]
  localparam int STENCIL [4][3][7] = '{
    '{ '{147, -360, 450, -400, 225, -72, 10},
       '{812, -3132, 5265, -5080, 2970, -972, 137},
       '{49, -232, 461, -496, 307, -104, 15} },
    '{ '{10, 77, -150, 100, -50, 15, -2},
       '{137, -147, -255, 470, -285, 93, -13},
       '{15, -56, 83, -64, 29, -8, 1} },
    '{ '{-2, 24, 35, -80, 30, -8, 1},
       '{-13, 228, -420, 200, 15, -12, 2},
       '{1, 8, -35, 48, -29, 8, -1} },
    '{ '{1, -9, 45, 0, -45, 9, -1},
       '{2, -27, 270, -490, 270, -27, 2},
       '{-1, 8, -13, 0, 13, -8, 1} }
  };

  // Coefficient lookup; order zero gives zero
  function automatic logic signed [COEF_BITS-1:0] spd_coef(
    input logic [1:0] pos,
    input logic [1:0] ord,
    input logic [2:0] tap
  );
    logic [1:0] row;
    row = ord - 2'd1;
    if (ord == ORD_NONE) begin
      return '0;
    end
    return COEF_BITS'(STENCIL[pos][row][tap]);
  endfunction

endpackage

>>> rtl/core/spd_if.sv
// Valid/ready channel interfaces for stencil items and results.
interface spd_in_if #(
  parameter int SAMPLE_BITS = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_0;
  logic signed [SAMPLE_BITS-1:0] sample_1;
  logic signed [SAMPLE_BITS-1:0] sample_2;
  logic signed [SAMPLE_BITS-1:0] sample_3;
  logic signed [SAMPLE_BITS-1:0] sample_4;
  logic signed [SAMPLE_BITS-1:0] sample_5;
  logic signed [SAMPLE_BITS-1:0] sample_6;
  logic [1:0]                    center_position;
  logic [1:0]                    deriv_order;

  modport source (
    output valid, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5,
           sample_6, center_position, deriv_order,
    input  ready
  );
  modport sink (
    input  valid, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5,
           sample_6, center_position, deriv_order,
    output ready
  );
endinterface

interface spd_out_if #(
  parameter int SAMPLE_BITS = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] derivative;
  logic                          saturated;
  logic                          bad_order;

  modport source (
    output valid, derivative, saturated, bad_order,
    input  ready
  );
  modport sink (
    input  valid, derivative, saturated, bad_order,
    output ready
  );
endinterface

>>> rtl/core/spd_dot.sv
// Input register and pipelined stencil dot product (products, pair sums, final sum).
module spd_dot #(
  parameter int SAMPLE_BITS = 32,
  parameter int SUM_BITS    = 47
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  spd_in_if.sink                     in_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic signed [SUM_BITS-1:0] sum_o,
  output spd_pkg::spd_tag_t          tag_o
);
  import spd_pkg::*;

  localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
  localparam int NSTAGE = 4;

  logic [NSTAGE-1:0] vld_q;
  logic [NSTAGE-1:0] adv;

  // Stage A: input register
  logic signed [SAMPLE_BITS-1:0] smp_q [7];
  logic [1:0]                    pos_q;
  logic [1:0]                    ord_q;
  // Stage B: tap products
  logic signed [PROD_BITS-1:0]   prod_d [7];
  logic signed [PROD_BITS-1:0]   prod_q [7];
  spd_tag_t                      tag_b_q;
  // Stage C: pair sums
  logic signed [SUM_BITS-1:0]    pair_d [4];
  logic signed [SUM_BITS-1:0]    pair_q [4];
  spd_tag_t                      tag_c_q;
  // Stage D: full sum
  logic signed [SUM_BITS-1:0]    sum_d;
  logic signed [SUM_BITS-1:0]    sum_q;
  spd_tag_t                      tag_d_q;

  // A stage moves when it is empty or the stage after it moves
  always_comb begin
    adv[NSTAGE-1] = ~vld_q[NSTAGE-1] | ready_i;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      adv[k] = ~vld_q[k] | adv[k+1];
    end
  end

  assign in_i.ready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Stage A load
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      smp_q[0] <= in_i.sample_0;
      smp_q[1] <= in_i.sample_1;
      smp_q[2] <= in_i.sample_2;
      smp_q[3] <= in_i.sample_3;
      smp_q[4] <= in_i.sample_4;
      smp_q[5] <= in_i.sample_5;
      smp_q[6] <= in_i.sample_6;
      pos_q    <= in_i.center_position;
      ord_q    <= in_i.deriv_order;
    end
  end

  // Tap products with the selected stencil row
  always_comb begin
    for (int k = 0; k < 7; k++) begin
      prod_d[k] = PROD_BITS'(smp_q[k]) * PROD_BITS'(spd_coef(pos_q, ord_q, 3'(k)));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      prod_q                <= prod_d;
      tag_b_q.bad_order     <= (ord_q == ORD_NONE);
      tag_b_q.deriv_order   <= ord_q;
    end
  end

  // Pair sums
  always_comb begin
    pair_d[0] = SUM_BITS'(prod_q[0]) + SUM_BITS'(prod_q[1]);
    pair_d[1] = SUM_BITS'(prod_q[2]) + SUM_BITS'(prod_q[3]);
    pair_d[2] = SUM_BITS'(prod_q[4]) + SUM_BITS'(prod_q[5]);
    pair_d[3] = SUM_BITS'(prod_q[6]);
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      pair_q  <= pair_d;
      tag_c_q <= tag_b_q;
    end
  end

  // Final sum
  assign sum_d = (pair_q[0] + pair_q[1]) + (pair_q[2] + pair_q[3]);

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      sum_q   <= sum_d;
      tag_d_q <= tag_c_q;
    end
  end

  assign valid_o = vld_q[NSTAGE-1];
  assign sum_o   = sum_q;
  assign tag_o   = tag_d_q;

endmodule

>>> rtl/core/spd_mul.sv
// Pipelined signed multiply of the stencil sum by the scale, built from four partial products.
module spd_mul #(
  parameter int SUM_BITS  = 47,
  parameter int PROD_BITS = 95
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  logic signed [SUM_BITS-1:0]           sum_i,
  input  logic signed [spd_pkg::SCALE_BITS-1:0] scale_i,
  input  logic                                 bad_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic signed [PROD_BITS-1:0]          prod_o,
  output logic                                 bad_o
);
  import spd_pkg::*;

  localparam int ALO = SUM_BITS / 2;
  localparam int AHI = SUM_BITS - ALO;
  localparam int BLO = SCALE_LO_BITS;
  localparam int BHI = SCALE_BITS - BLO;
  localparam int NSTAGE = 3;

  logic [NSTAGE-1:0] vld_q;
  logic [NSTAGE-1:0] adv;
  logic [NSTAGE-1:0] bad_q;

  // Operand halves: low halves unsigned, high halves signed
  logic signed [ALO:0]   a_lo;
  logic signed [AHI-1:0] a_hi;
  logic signed [BLO:0]   b_lo;
  logic signed [BHI-1:0] b_hi;

  logic signed [ALO+BLO+1:0]   pll_q;
  logic signed [ALO+BHI:0]     plh_q;
  logic signed [AHI+BLO:0]     phl_q;
  logic signed [AHI+BHI-1:0]   phh_q;
  logic signed [PROD_BITS-1:0] x_q;
  logic signed [PROD_BITS-1:0] y_q;
  logic signed [PROD_BITS-1:0] prod_q;

  always_comb begin
    adv[NSTAGE-1] = ~vld_q[NSTAGE-1] | ready_i;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      adv[k] = ~vld_q[k] | adv[k+1];
    end
  end

  assign ready_o = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= valid_i;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign a_lo = $signed({1'b0, sum_i[ALO-1:0]});
  assign a_hi = $signed(sum_i[SUM_BITS-1:ALO]);
  assign b_lo = $signed({1'b0, scale_i[BLO-1:0]});
  assign b_hi = $signed(scale_i[SCALE_BITS-1:BLO]);

  // Stage E: four partial products
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      pll_q    <= a_lo * b_lo;
      plh_q    <= a_lo * b_hi;
      phl_q    <= a_hi * b_lo;
      phh_q    <= a_hi * b_hi;
      bad_q[0] <= bad_i;
    end
  end

  // Stage F: align and add in pairs
  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      x_q      <= PROD_BITS'(pll_q) + (PROD_BITS'(plh_q) <<< BLO);
      y_q      <= (PROD_BITS'(phl_q) <<< ALO) + (PROD_BITS'(phh_q) <<< (ALO + BLO));
      bad_q[1] <= bad_q[0];
    end
  end

  // Stage G: full product
  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      prod_q   <= x_q + y_q;
      bad_q[2] <= bad_q[1];
    end
  end

  assign valid_o = vld_q[NSTAGE-1];
  assign prod_o  = prod_q;
  assign bad_o   = bad_q[NSTAGE-1];

endmodule

>>> rtl/core/seven_point_derivative_stencil_core.sv
// An accepted item passes stages A to D, E to G and the output register before its result is valid.
// Throughput: one item per cycle unless the output stalls; eight pipeline stages, each with its own valid bit.
// in_i.ready drops only when every stage holds an item and the output is stalled.
// Reset clears all valid bits and sets the three scale registers to 1.0 (Q24).
// Top level of the seven-point finite difference stencil core.
module seven_point_derivative_stencil_core #(
  parameter int SAMPLE_BITS     = 32,
  parameter int SCALE_FRAC_BITS = 24
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  spd_in_if.sink                                 in_i,
  spd_out_if.source                              out_o,
  input  logic                                   cfg_we_i,
  input  logic [spd_pkg::CFG_IDX_BITS-1:0]       cfg_idx_i,
  input  logic [spd_pkg::SCALE_BITS-1:0]         cfg_data_i
);
  import spd_pkg::*;

  localparam int SUM_BITS  = SAMPLE_BITS + SUM_GROWTH;
  localparam int PROD_BITS = SUM_BITS + SCALE_BITS;
  localparam int HI_LSB    = SCALE_FRAC_BITS + SAMPLE_BITS - 1;

  // Scale registers
  logic signed [SCALE_BITS-1:0] scale_first_q;
  logic signed [SCALE_BITS-1:0] scale_second_q;
  logic signed [SCALE_BITS-1:0] scale_third_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_first_q  <= SCALE_RESET;
      scale_second_q <= SCALE_RESET;
      scale_third_q  <= SCALE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SCALE_FIRST:  scale_first_q  <= cfg_data_i;
        CFG_SCALE_SECOND: scale_second_q <= cfg_data_i;
        CFG_SCALE_THIRD:  scale_third_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Dot product pipeline
  logic                       dot_valid;
  logic                       dot_ready;
  logic signed [SUM_BITS-1:0] dot_sum;
  spd_tag_t                   dot_tag;

  spd_dot #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_BITS    (SUM_BITS)
  ) u_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (dot_valid),
    .ready_i (dot_ready),
    .sum_o   (dot_sum),
    .tag_o   (dot_tag)
  );

  // Scale of the item's order
  logic signed [SCALE_BITS-1:0] scale_sel;

  always_comb begin
    unique case (dot_tag.deriv_order)
      ORD_FIRST:  scale_sel = scale_first_q;
      ORD_SECOND: scale_sel = scale_second_q;
      ORD_THIRD:  scale_sel = scale_third_q;
      default:    scale_sel = scale_first_q;
    endcase
  end

  // Scale multiply pipeline
  logic                        mul_valid;
  logic                        mul_ready;
  logic signed [PROD_BITS-1:0] mul_prod;
  logic                        mul_bad;

  spd_mul #(
    .SUM_BITS  (SUM_BITS),
    .PROD_BITS (PROD_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dot_valid),
    .ready_o (dot_ready),
    .sum_i   (dot_sum),
    .scale_i (scale_sel),
    .bad_i   (dot_tag.bad_order),
    .valid_o (mul_valid),
    .ready_i (mul_ready),
    .prod_o  (mul_prod),
    .bad_o   (mul_bad)
  );

  // Shift by the fraction width and clip to the sample range
  logic [PROD_BITS-1-HI_LSB:0]   prod_top;
  logic                          fits;
  logic signed [SAMPLE_BITS-1:0] deriv_d;
  logic                          sat_d;

  assign prod_top = mul_prod[PROD_BITS-1:HI_LSB];
  assign fits     = (&prod_top) | ~(|prod_top);

  always_comb begin
    if (mul_bad) begin
      deriv_d = '0;
      sat_d   = 1'b0;
    end else if (!fits) begin
      deriv_d = mul_prod[PROD_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                      : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      sat_d   = 1'b1;
    end else begin
      deriv_d = mul_prod[HI_LSB:SCALE_FRAC_BITS];
      sat_d   = 1'b0;
    end
  end

  // Output register
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] deriv_q;
  logic                          sat_q;
  logic                          bad_q;

  assign mul_ready = ~out_valid_q | out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (mul_ready) begin
      out_valid_q <= mul_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_ready) begin
      deriv_q <= deriv_d;
      sat_q   <= sat_d;
      bad_q   <= mul_bad;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.derivative = deriv_q;
  assign out_o.saturated  = sat_q;
  assign out_o.bad_order  = bad_q;

  // A bad order gives a zero, unclipped result
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.bad_order |-> out_o.derivative == '0 && !out_o.saturated)
    else $error("bad order result not zero");

  // A clipped result sits at one end of the range
  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.saturated |->
      out_o.derivative == {1'b1, {(SAMPLE_BITS-1){1'b0}}} ||
      out_o.derivative == {1'b0, {(SAMPLE_BITS-1){1'b1}}})
    else $error("saturated result not at a rail");

  // Input back-pressure only comes from a stalled output
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid && !out_o.ready)
    else $error("input stalled without output stall");

endmodule

>>> verif/tb.sv
// Self-checking testbench for the seven-point derivative stencil core.
`timescale 1ns / 1ps

module tb;
  import spd_pkg::*;

  // Window positions: 3 is central, 0 fully one-sided
  localparam logic [1:0] POS_EDGE    = 2'd0;
  localparam logic [1:0] POS_NEAR    = 2'd1;
  localparam logic [1:0] POS_INNER   = 2'd2;
  localparam logic [1:0] POS_CENTRAL = 2'd3;

  // Register index past the last scale; writes to it are dropped
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE = 2'd3;

  localparam int FRAC_BITS    = 24;
  localparam int PHASE_ITEMS  = 75;
  localparam int NUM_PHASES   = 6;
  localparam int TAIL_CYCLES  = 16;
  localparam int STALL_LIMIT  = 2000;

  localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S_MIN = 32'h8000_0000;
  localparam logic [31:0] S_ZRO = 32'h0000_0000;
  localparam logic [31:0] S_ONE = 32'h0000_0001;
  localparam logic [31:0] S_NEG = 32'hFFFF_FFFF;

  localparam logic [SCALE_BITS-1:0] SCL_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [SCALE_BITS-1:0] SCL_MIN = 48'h8000_0000_0000;

  localparam logic signed [127:0] SAT_HI = 128'sh7FFF_FFFF;
  localparam logic signed [127:0] SAT_LO = -128'sh8000_0000;

  typedef struct packed {
    logic [0:6][31:0] smp;
    logic [1:0]       pos;
    logic [1:0]       ord;
  } window_t;

  typedef struct packed {
    logic [31:0] deriv;
    logic        sat;
    logic        bad;
  } deriv_t;

  typedef struct packed {
    window_t win;
    logic    chk;
    deriv_t  want;
  } dir_row_t;

  localparam deriv_t RES_BAD   = {32'h0, 1'b0, 1'b1};
  localparam deriv_t RES_ZERO  = {32'h0, 1'b0, 1'b0};
  localparam deriv_t RES_SATP  = {32'h7FFF_FFFF, 1'b1, 1'b0};
  localparam deriv_t RES_SATN  = {32'h8000_0000, 1'b1, 1'b0};
  localparam deriv_t NO_CHECK  = '0;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [SCALE_BITS-1:0]   cfg_data_i;

  spd_in_if  #(.SAMPLE_BITS(32)) in_ch ();
  spd_out_if #(.SAMPLE_BITS(32)) out_ch ();

  seven_point_derivative_stencil_core #(
    .SAMPLE_BITS(32),
    .SCALE_FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch),
    .out_o     (out_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // Predictor copy of the scale registers
  logic signed [SCALE_BITS-1:0] scale_q [3];

  deriv_t   pending_q [$];
  dir_row_t dir_tab [$];
  int       items_sent;
  int       results_seen;
  int       mismatches;
  int       idle_cycles;
  logic     tx_calm;
  logic     rx_calm;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Stencil coefficient row for a position and a nonzero order
  function automatic logic [0:6][15:0] tap_row(logic [1:0] pos, logic [1:0] ord);
    logic [0:6][15:0] row;
    row = '0;
    case ({pos, ord})
      {POS_EDGE, ORD_FIRST}:     row = {16'sd147, -16'sd360, 16'sd450, -16'sd400,
                                        16'sd225, -16'sd72, 16'sd10};
      {POS_EDGE, ORD_SECOND}:    row = {16'sd812, -16'sd3132, 16'sd5265, -16'sd5080,
                                        16'sd2970, -16'sd972, 16'sd137};
      {POS_EDGE, ORD_THIRD}:     row = {16'sd49, -16'sd232, 16'sd461, -16'sd496,
                                        16'sd307, -16'sd104, 16'sd15};
      {POS_NEAR, ORD_FIRST}:     row = {16'sd10, 16'sd77, -16'sd150, 16'sd100,
                                        -16'sd50, 16'sd15, -16'sd2};
      {POS_NEAR, ORD_SECOND}:    row = {16'sd137, -16'sd147, -16'sd255, 16'sd470,
                                        -16'sd285, 16'sd93, -16'sd13};
      {POS_NEAR, ORD_THIRD}:     row = {16'sd15, -16'sd56, 16'sd83, -16'sd64,
                                        16'sd29, -16'sd8, 16'sd1};
      {POS_INNER, ORD_FIRST}:    row = {-16'sd2, 16'sd24, 16'sd35, -16'sd80,
                                        16'sd30, -16'sd8, 16'sd1};
      {POS_INNER, ORD_SECOND}:   row = {-16'sd13, 16'sd228, -16'sd420, 16'sd200,
                                        16'sd15, -16'sd12, 16'sd2};
      {POS_INNER, ORD_THIRD}:    row = {16'sd1, 16'sd8, -16'sd35, 16'sd48,
                                        -16'sd29, 16'sd8, -16'sd1};
      {POS_CENTRAL, ORD_FIRST}:  row = {16'sd1, -16'sd9, 16'sd45, 16'sd0,
                                        -16'sd45, 16'sd9, -16'sd1};
      {POS_CENTRAL, ORD_SECOND}: row = {16'sd2, -16'sd27, 16'sd270, -16'sd490,
                                        16'sd270, -16'sd27, 16'sd2};
      {POS_CENTRAL, ORD_THIRD}:  row = {-16'sd1, 16'sd8, -16'sd13, 16'sd0,
                                        16'sd13, -16'sd8, 16'sd1};
      default:                   row = '0;
    endcase
    return row;
  endfunction

  // Exact dot product, full-width scale multiply, floor shift, clip to 32 bits
  function automatic deriv_t predict_derivative(window_t w);
    logic [0:6][15:0]             row;
    logic signed [63:0]           acc;
    logic signed [63:0]           s;
    logic signed [63:0]           c;
    logic signed [SCALE_BITS-1:0] scl;
    logic signed [127:0]          prod;
    logic signed [127:0]          wide_scl;
    logic signed [127:0]          q;
    deriv_t                       r;
    int                           k;
    r = '0;
    if (w.ord == ORD_NONE) begin
      r.bad = 1'b1;
      return r;
    end
    row = tap_row(w.pos, w.ord);
    acc = '0;
    for (k = 0; k < 7; k++) begin
      s = $signed(w.smp[k]);
      c = $signed(row[k]);
      acc = acc + s * c;
    end
    case (w.ord)
      ORD_FIRST:  scl = scale_q[CFG_SCALE_FIRST];
      ORD_SECOND: scl = scale_q[CFG_SCALE_SECOND];
      default:    scl = scale_q[CFG_SCALE_THIRD];
    endcase
    prod = acc;
    wide_scl = scl;
    prod = prod * wide_scl;
    q = prod >>> FRAC_BITS;
    if (q > SAT_HI) begin
      r.deriv = 32'h7FFF_FFFF;
      r.sat = 1'b1;
    end else if (q < SAT_LO) begin
      r.deriv = 32'h8000_0000;
      r.sat = 1'b1;
    end else begin
      r.deriv = q[31:0];
    end
    return r;
  endfunction

  // Random window: mostly smooth or small data, some full-range noise, extremes and single spikes
  function automatic window_t gen_window();
    window_t            w;
    logic signed [63:0] b;
    logic signed [63:0] d1;
    logic signed [63:0] d2;
    logic signed [63:0] v;
    int                 mode;
    int                 r;
    int                 hot;
    int                 k;
    w = '0;
    w.pos = 2'($urandom_range(0, 3));
    r = $urandom_range(0, 9);
    if (r == 0) w.ord = ORD_NONE;
    else if (r < 4) w.ord = ORD_FIRST;
    else if (r < 7) w.ord = ORD_SECOND;
    else w.ord = ORD_THIRD;
    mode = $urandom_range(0, 9);
    b  = $signed($urandom) >>> $urandom_range(0, 10);
    d1 = $signed($urandom) >>> $urandom_range(6, 20);
    d2 = $signed($urandom) >>> $urandom_range(10, 24);
    hot = $urandom_range(0, 6);
    for (k = 0; k < 7; k++) begin
      case (mode)
        0, 1: w.smp[k] = $urandom;
        2, 3, 4, 5: begin
          v = b + d1 * k + d2 * k * k;
          w.smp[k] = v[31:0];
        end
        6, 7: w.smp[k] = $signed($urandom) >>> 20;
        8: begin
          case ($urandom_range(0, 4))
            0:       w.smp[k] = S_MAX;
            1:       w.smp[k] = S_MIN;
            2:       w.smp[k] = S_ONE;
            3:       w.smp[k] = S_NEG;
            default: w.smp[k] = S_ZRO;
          endcase
        end
        default: w.smp[k] = (k == hot) ? $urandom : S_ZRO;
      endcase
    end
    return w;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("ERROR: %s", msg);
  endtask

  // Present one item, hold it until accepted, queue its expected result
  task automatic send_window(window_t w, logic chk, deriv_t want);
    int gap;
    if ($urandom_range(0, 24) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.sample_0        <= w.smp[0];
    in_ch.sample_1        <= w.smp[1];
    in_ch.sample_2        <= w.smp[2];
    in_ch.sample_3        <= w.smp[3];
    in_ch.sample_4        <= w.smp[4];
    in_ch.sample_5        <= w.smp[5];
    in_ch.sample_6        <= w.smp[6];
    in_ch.center_position <= w.pos;
    in_ch.deriv_order     <= w.ord;
    in_ch.valid           <= 1'b1;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    items_sent++;
    pending_q.push_back(chk ? want : predict_derivative(w));
  endtask

  // Register write; the caller lowers the enable after the last one
  task automatic write_scale(logic [CFG_IDX_BITS-1:0] idx, logic [SCALE_BITS-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (idx <= CFG_SCALE_THIRD) scale_q[idx] = val;
  endtask

  // Wait until every queued window has come back
  task automatic drain();
    while (results_seen != items_sent) @(posedge clk_i);
  endtask

  // Result side: random back-pressure, compare against the oldest expectation
  initial begin
    deriv_t got;
    deriv_t want;
    int     stall;
    out_ch.ready <= 1'b0;
    rx_calm = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 24) == 0) rx_calm = !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (out_ch.valid !== 1'b1);
      got = {out_ch.derivative, out_ch.saturated, out_ch.bad_order};
      results_seen <= results_seen + 1;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
      end else begin
        want = pending_q.pop_front();
        if (got.deriv !== want.deriv)
          report_mismatch($sformatf("result %0d: derivative %h, want %h",
                                    results_seen, got.deriv, want.deriv));
        if (got.sat !== want.sat)
          report_mismatch($sformatf("result %0d: saturated %b, want %b",
                                    results_seen, got.sat, want.sat));
        if (got.bad !== want.bad)
          report_mismatch($sformatf("result %0d: bad_order %b, want %b",
                                    results_seen, got.bad, want.bad));
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Main sequence: reset, directed table, random phases over several scale settings
  initial begin
    logic [SCALE_BITS-1:0] scl [3];
    logic [63:0]           raw;
    int                    ph;
    int                    n;
    int                    j;
    rst_ni                <= 1'b0;
    cfg_we_i              <= 1'b0;
    cfg_idx_i             <= '0;
    cfg_data_i            <= '0;
    in_ch.valid           <= 1'b0;
    in_ch.sample_0        <= '0;
    in_ch.sample_1        <= '0;
    in_ch.sample_2        <= '0;
    in_ch.sample_3        <= '0;
    in_ch.sample_4        <= '0;
    in_ch.sample_5        <= '0;
    in_ch.sample_6        <= '0;
    in_ch.center_position <= '0;
    in_ch.deriv_order     <= '0;
    items_sent   = 0;
    results_seen = 0;
    mismatches   = 0;
    idle_cycles  = 0;
    tx_calm      = 1'b0;
    for (j = 0; j < 3; j++) scale_q[j] = SCALE_RESET;

    // Directed rows under the reset scale of 1.0
    // order zero ignores the window
    dir_tab.push_back({S_ZRO, S_ZRO, S_ZRO, S_ZRO, S_ZRO, S_ZRO, S_ZRO,
                       POS_EDGE, ORD_NONE, 1'b1, RES_BAD});
    dir_tab.push_back({S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX,
                       POS_CENTRAL, ORD_NONE, 1'b1, RES_BAD});
    dir_tab.push_back({S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN,
                       POS_INNER, ORD_NONE, 1'b1, RES_BAD});
    // zero and constant windows give zero
    dir_tab.push_back({S_ZRO, S_ZRO, S_ZRO, S_ZRO, S_ZRO, S_ZRO, S_ZRO,
                       POS_CENTRAL, ORD_FIRST, 1'b1, RES_ZERO});
    dir_tab.push_back({S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX,
                       POS_NEAR, ORD_FIRST, 1'b1, RES_ZERO});
    dir_tab.push_back({S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN,
                       POS_INNER, ORD_THIRD, 1'b1, RES_ZERO});
    // unit impulses read back a single coefficient
    dir_tab.push_back({S_ZRO, S_ZRO, S_ONE, S_ZRO, S_ZRO, S_ZRO, S_ZRO,
                       POS_CENTRAL, ORD_FIRST, 1'b1, {32'sd45, 1'b0, 1'b0}});
    dir_tab.push_back({S_ZRO, S_ZRO, S_ZRO, S_ONE, S_ZRO, S_ZRO, S_ZRO,
                       POS_CENTRAL, ORD_SECOND, 1'b1, {-32'sd490, 1'b0, 1'b0}});
    dir_tab.push_back({S_ZRO, S_ZRO, S_ZRO, S_ZRO, S_ONE, S_ZRO, S_ZRO,
                       POS_CENTRAL, ORD_THIRD, 1'b1, {32'sd13, 1'b0, 1'b0}});
    dir_tab.push_back({S_NEG, S_ZRO, S_ZRO, S_ZRO, S_ZRO, S_ZRO, S_ZRO,
                       POS_EDGE, ORD_FIRST, 1'b1, {-32'sd147, 1'b0, 1'b0}});
    // clipping high and low
    dir_tab.push_back({S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX,
                       POS_EDGE, ORD_SECOND, 1'b1, RES_SATP});
    dir_tab.push_back({S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN,
                       POS_EDGE, ORD_SECOND, 1'b1, RES_SATN});
    dir_tab.push_back({S_ZRO, S_ZRO, S_MAX, S_ZRO, S_ZRO, S_ZRO, S_ZRO,
                       POS_CENTRAL, ORD_FIRST, 1'b1, RES_SATP});
    dir_tab.push_back({S_ZRO, S_ZRO, S_ZRO, S_ZRO, S_MAX, S_ZRO, S_ZRO,
                       POS_CENTRAL, ORD_FIRST, 1'b1, RES_SATN});
    // further position and order pairs, including the remaining ones, checked by prediction
    dir_tab.push_back({32'd5, -32'sd3, 32'd100, 32'd7, -32'sd2000, 32'd9, 32'd1,
                       POS_EDGE, ORD_FIRST, 1'b0, NO_CHECK});
    dir_tab.push_back({32'd1000, 32'd1100, 32'd1250, 32'd1450, 32'd1700, 32'd2000, 32'd2350,
                       POS_EDGE, ORD_THIRD, 1'b0, NO_CHECK});
    dir_tab.push_back({-32'sd40, 32'd12, 32'd33, -32'sd1, 32'd8, 32'd70000, -32'sd5,
                       POS_NEAR, ORD_SECOND, 1'b0, NO_CHECK});
    dir_tab.push_back({32'h0123_4567, 32'h0765_4321, 32'h00FF_00FF, 32'h1000_0000,
                       32'hF000_0000, 32'h0000_FFFF, 32'h7000_0000,
                       POS_NEAR, ORD_THIRD, 1'b0, NO_CHECK});
    dir_tab.push_back({32'd3, 32'd9, 32'd27, 32'd81, 32'd243, 32'd729, 32'd2187,
                       POS_INNER, ORD_FIRST, 1'b0, NO_CHECK});
    dir_tab.push_back({-32'sd300000, 32'd12345, 32'd0, 32'd99, -32'sd7, 32'd65536, 32'd2,
                       POS_INNER, ORD_SECOND, 1'b0, NO_CHECK});
    dir_tab.push_back({32'hDEAD_BEEF, 32'h0BAD_F00D, 32'h1234_5678, 32'h8765_4321,
                       32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F,
                       POS_CENTRAL, ORD_SECOND, 1'b0, NO_CHECK});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_window(dir_tab[i].win, dir_tab[i].chk, dir_tab[i].want);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      in_ch.valid <= 1'b0;
      drain();
      case (ph)
        0: begin
          scl[0] = SCL_MAX;
          scl[1] = SCL_MIN;
          scl[2] = '0;
        end
        1: begin
          scl[0] = 48'd1;
          scl[1] = 48'hFFFF_FFFF_FFFF;
          scl[2] = 48'hFFFF_FF00_0000;
        end
        2: begin
          // spacing of one quarter
          scl[0] = 48'd1118481;
          scl[1] = 48'd1491308;
          scl[2] = 48'd134217728;
        end
        3: begin
          for (j = 0; j < 3; j++) begin
            raw = {$urandom, $urandom};
            scl[j] = raw[SCALE_BITS-1:0];
          end
        end
        4: begin
          for (j = 0; j < 3; j++) begin
            raw = $signed($urandom) >>> $urandom_range(1, 12);
            scl[j] = raw[SCALE_BITS-1:0];
          end
        end
        default: begin
          raw = {$urandom, $urandom};
          scl[0] = SCL_MIN;
          scl[1] = SCL_MAX;
          scl[2] = raw[SCALE_BITS-1:0];
        end
      endcase
      write_scale(CFG_SCALE_FIRST, scl[0]);
      write_scale(CFG_SCALE_SECOND, scl[1]);
      write_scale(CFG_SCALE_THIRD, scl[2]);
      raw = {$urandom, $urandom};
      write_scale(CFG_IDX_SPARE, raw[SCALE_BITS-1:0]);
      cfg_we_i <= 1'b0;
      for (n = 0; n < PHASE_ITEMS; n++) send_window(gen_window(), 1'b0, NO_CHECK);
    end

    in_ch.valid <= 1'b0;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
